// ----- hdl/drbd_pkg.sv -----
// Shared types, codes and constants for the detection row box decoder.
`default_nettype none
package drbd_pkg;

    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 16384;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_RATIO   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd6;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_SCALE = 3'd1;
    localparam logic [2:0] OP_PAD   = 3'd2;
    localparam logic [2:0] OP_MULLO = 3'd3;
    localparam logic [2:0] OP_MULHI = 3'd4;
    localparam logic [2:0] OP_ROUND = 3'd5;
    localparam logic [2:0] OP_EDGE  = 3'd6;
    localparam logic [2:0] OP_FINAL = 3'd7;

    typedef struct packed {
        logic signed [31:0] tensor_value;
        logic               last_row_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [29:0] box_left;
        logic [29:0] box_top;
        logic [29:0] box_w;
        logic [29:0] box_h;
        logic [30:0] score;
        logic [13:0] row_number;
        logic        frame_done;
    } out_item_t;

    typedef struct packed {
        logic       take;
        logic [2:0] op;
        logic [1:0] coord;
    } dp_cmd_t;

    typedef struct packed {
        logic row_end;
        logic keep;
    } dp_status_t;

endpackage
`default_nettype wire

// ----- hdl/detection_row_box_decoder.sv -----
// Top level of the detection row box decoder.
//
//  channel  dir  handshake           payload
//  in       in   in_valid/in_stall   in_item_t  (tensor value, last row flag)
//  out      out  out_valid/out_stall out_item_t (clipped box, score, row)
//  cfg      in   cfg_write           cfg_index, cfg_data
//
// Tensor values are taken one per cycle while no row end is in progress.
// A kept row end runs 4 coordinates x 5 steps through the scale/ratio
// arithmetic, plus decide, edge and final steps.
// A dropped row end adds only the decide step.
// Reset is asynchronous; all control and config return to defaults.
// A pending result waits in the output register; the final value of the next
// row stalls until that request is taken.
`default_nettype none
module detection_row_box_decoder
    import drbd_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    drbd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    drbd_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire

// ----- hdl/drbd_ctrl.sv -----
// Controller: sequences the box arithmetic after a kept row ends.
`default_nettype none
module drbd_ctrl
    import drbd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_SCALE  = 4'd2;
    localparam logic [3:0] S_PAD    = 4'd3;
    localparam logic [3:0] S_MULLO  = 4'd4;
    localparam logic [3:0] S_MULHI  = 4'd5;
    localparam logic [3:0] S_ROUND  = 4'd6;
    localparam logic [3:0] S_EDGE   = 4'd7;
    localparam logic [3:0] S_FINAL  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] coord_reg, coord_next;

    always_comb
    begin
        state_next = state_reg;
        coord_next = coord_reg;
        cmd.take   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.coord  = coord_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (status.row_end)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                coord_next = 2'd0;
                state_next = status.keep ? S_SCALE : S_IDLE;
            end
            S_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = S_PAD;
            end
            S_PAD:
            begin
                cmd.op     = OP_PAD;
                state_next = S_MULLO;
            end
            S_MULLO:
            begin
                cmd.op     = OP_MULLO;
                state_next = S_MULHI;
            end
            S_MULHI:
            begin
                cmd.op     = OP_MULHI;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.op = OP_ROUND;
                if (coord_reg == 2'd3)
                    state_next = S_EDGE;
                else
                begin
                    coord_next = coord_reg + 2'd1;
                    state_next = S_SCALE;
                end
            end
            S_EDGE:
            begin
                cmd.op     = OP_EDGE;
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.op     = OP_FINAL;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            coord_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            coord_reg <= coord_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/drbd_datapath.sv -----
// Datapath: row capture, config registers, box arithmetic and output register.
`default_nettype none
module drbd_datapath
    import drbd_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int POS_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [8:0]       MAXC9 = 9'(MAX_COLUMNS);
    localparam logic [ROW_W:0]   MAXR  = (ROW_W + 1)'(MAX_ROWS);

    // configuration
    logic [7:0]  column_count_reg;
    logic [13:0] frame_width_reg, frame_height_reg;
    logic [12:0] pad_left_reg, pad_top_reg;
    logic [23:0] inverse_ratio_reg;
    logic [16:0] score_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg    <= 8'd84;
            frame_width_reg     <= 14'd640;
            frame_height_reg    <= 14'd640;
            pad_left_reg        <= 13'd0;
            pad_top_reg         <= 13'd0;
            inverse_ratio_reg   <= 24'd65536;
            score_threshold_reg <= 17'd16384;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COLUMN_COUNT:    column_count_reg    <= cfg_data[7:0];
                REG_FRAME_WIDTH:     frame_width_reg     <= cfg_data[13:0];
                REG_FRAME_HEIGHT:    frame_height_reg    <= cfg_data[13:0];
                REG_PAD_LEFT:        pad_left_reg        <= cfg_data[12:0];
                REG_PAD_TOP:         pad_top_reg         <= cfg_data[12:0];
                REG_INVERSE_RATIO:   inverse_ratio_reg   <= cfg_data;
                REG_SCORE_THRESHOLD: score_threshold_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // row capture
    logic [POS_W-1:0]   pos_reg;
    logic [ROW_W-1:0]   row_reg;
    logic signed [31:0] raw_reg [4];
    logic signed [31:0] best_reg;
    logic [POS_W-1:0]   cls_reg;
    logic signed [31:0] class_reg;
    logic               corner_end_reg, frame_done_reg;
    logic [ROW_W-1:0]   row_end_num_reg;

    logic [8:0]         cnt;
    logic               corner_c, at_end, accept;
    logic signed [31:0] best_base;
    logic [POS_W-1:0]   cls_base;
    logic signed [31:0] v;
    logic [ROW_W:0]     row_inc;

    always_comb
    begin
        cnt = {1'b0, column_count_reg};
        if (cnt < 9'd5)
            cnt = 9'd5;
        if (cnt > MAXC9)
            cnt = MAXC9;
        corner_c = (cnt == 9'd6);
        at_end   = 9'(pos_reg) >= (cnt - 9'd1);
    end

    assign in_stall = !cmd.take || (out_valid && at_end);
    assign accept   = in_valid && !in_stall;
    assign v        = in_data.tensor_value;
    assign best_base = (pos_reg == '0) ? 32'sd0 : best_reg;
    assign cls_base  = (pos_reg == '0) ? '0 : cls_reg;
    assign row_inc   = {1'b0, row_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            row_reg        <= '0;
            best_reg       <= '0;
            cls_reg        <= '0;
            class_reg      <= '0;
            corner_end_reg <= 1'b0;
        end
        else if (accept)
        begin
            best_reg <= best_base;
            cls_reg  <= cls_base;
            if (pos_reg < POS_W'(4))
                ;
            else if (corner_c)
            begin
                if (pos_reg == POS_W'(4))
                    best_reg <= v;
                else
                    class_reg <= v;
            end
            else if (v > best_base)
            begin
                best_reg <= v;
                cls_reg  <= pos_reg - POS_W'(4);
            end
            if (at_end)
            begin
                pos_reg        <= '0;
                corner_end_reg <= corner_c;
                if (in_data.last_row_of_frame || row_inc >= MAXR)
                    row_reg <= '0;
                else
                    row_reg <= row_inc[ROW_W-1:0];
            end
            else
                pos_reg <= pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pos_reg < POS_W'(4))
            raw_reg[pos_reg[1:0]] <= v;
        if (accept && at_end)
        begin
            frame_done_reg  <= in_data.last_row_of_frame;
            row_end_num_reg <= row_reg;
        end
    end

    assign status.row_end = accept && at_end;
    assign status.keep = (corner_end_reg ? (class_reg > -32'sd32768 && class_reg < 32'sd32768)
                                         : (cls_reg == '0))
                         && (best_reg >= $signed({15'd0, score_threshold_reg}));

    // box arithmetic, one coordinate at a time
    logic signed [33:0] prod_reg;
    logic [40:0]        lo_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] val_reg [4];
    logic [29:0]        el_reg, et_reg, er_reg, eb_reg;

    logic               small_c, use_pad;
    logic [13:0]        sfac;
    logic signed [46:0] sprod;
    logic [12:0]        padv;
    logic signed [41:0] hprod;
    logic signed [63:0] l_c, t_c, r_c, b_c;
    logic [30:0]        w_c, h_c;

    function automatic logic [29:0] clip(input logic signed [63:0] x, input logic [13:0] f);
        logic signed [63:0] hi;
        hi = $signed({34'd0, f, 16'd0});
        if (x < 0)
            return 30'd0;
        else if (x > hi)
            return hi[29:0];
        else
            return x[29:0];
    endfunction

    always_comb
    begin
        small_c = 1'b1;
        for (int i = 0; i < 4; i++)
            if (raw_reg[i] > 32'sd131072 || raw_reg[i] < -32'sd131072)
                small_c = 1'b0;
        use_pad = corner_end_reg || !cmd.coord[1];
        sfac    = small_c ? (cmd.coord[0] ? frame_height_reg : frame_width_reg) : 14'd1;
        sprod   = raw_reg[cmd.coord] * $signed({1'b0, sfac});
        padv    = cmd.coord[0] ? pad_top_reg : pad_left_reg;
        hprod   = $signed(prod_reg[33:17]) * $signed({1'b0, inverse_ratio_reg});
        if (corner_end_reg)
        begin
            l_c = val_reg[0];
            t_c = val_reg[1];
            r_c = val_reg[2];
            b_c = val_reg[3];
        end
        else
        begin
            l_c = val_reg[0] - val_reg[2];
            r_c = val_reg[0] + val_reg[2];
            t_c = val_reg[1] - val_reg[3];
            b_c = val_reg[1] + val_reg[3];
        end
        w_c = {1'b0, er_reg} - {1'b0, el_reg};
        h_c = {1'b0, eb_reg} - {1'b0, et_reg};
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_SCALE: prod_reg <= sprod[33:0];
            OP_PAD:
                if (use_pad)
                    prod_reg <= prod_reg - $signed({5'd0, padv, 16'd0});
            OP_MULLO: lo_reg <= 41'(prod_reg[16:0] * inverse_ratio_reg);
            OP_MULHI: acc_reg <= ($signed({{22{hprod[41]}}, hprod}) <<< 17)
                                 + $signed({23'd0, lo_reg});
            OP_ROUND:
                if (use_pad)
                    val_reg[cmd.coord] <= (acc_reg + 64'sd32768) >>> 16;
                else
                    val_reg[cmd.coord] <= (acc_reg + 64'sd65536) >>> 17;
            OP_EDGE:
            begin
                el_reg <= clip(l_c, frame_width_reg);
                er_reg <= clip(r_c, frame_width_reg);
                et_reg <= clip(t_c, frame_height_reg);
                eb_reg <= clip(b_c, frame_height_reg);
            end
            OP_NONE, OP_FINAL: ;
            default: ;
        endcase
    end

    // output register
    logic box_ok;
    assign box_ok = (cmd.op == OP_FINAL) && (er_reg > el_reg) && (eb_reg > et_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (box_ok)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (box_ok)
        begin
            out_data.box_left   <= el_reg;
            out_data.box_top    <= et_reg;
            out_data.box_w      <= w_c[29:0];
            out_data.box_h      <= h_c[29:0];
            out_data.score      <= best_reg[30:0];
            out_data.row_number <= 14'(row_end_num_reg);
            out_data.frame_done <= frame_done_reg;
        end
    end

    // a new box only lands in an empty output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        box_ok |-> !out_valid)
        else $error("box loaded over pending request");
    // the column position restarts after a row end
    a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && at_end) |=> (pos_reg == '0))
        else $error("column position not cleared at row end");
    // no input taken while the arithmetic runs
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != OP_NONE) |-> !accept)
        else $error("input accepted during box math");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the detection row box decoder.
`default_nettype none
module tb_top;
    import drbd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    detection_row_box_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies
    int unsigned m_count, m_fw, m_fh, m_pad_l, m_pad_t, m_ratio, m_thresh;
    // decoder state copies
    int unsigned col_pos, row_pos;
    longint      raw_xy [4];
    longint      lead_score;
    int unsigned best_class;
    longint      class_val;

    out_item_t   box_q [$];
    int          errors;
    int          items_sent;
    int          max_gap;
    int          burst_left;
    int          stall_pct;
    int          hold_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("** detection_row_box_decoder: FAILED **");
        $finish;
    end

    function automatic longint abs64(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint round_shift(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint x, longint hi);
        if (x < 0)
            return 0;
        if (x > hi)
            return hi;
        return x;
    endfunction

    function automatic int unsigned eff_count();
        if (m_count < 5)
            return 5;
        if (m_count > DEF_MAX_COLUMNS)
            return DEF_MAX_COLUMNS;
        return m_count;
    endfunction

    // Advance the decoder copy by one accepted value; queue a box if one is due.
    task automatic predict_box(in_item_t it);
        longint      v, m, sx, sy, px, py, ir, fw, fh;
        longint      l, t, r, b, w, h, cx, cy, hw, hh;
        int unsigned cnt;
        bit          corner, keep;
        out_item_t   box;
        v = longint'(it.tensor_value);
        cnt = eff_count();
        corner = (cnt == 6);
        if (col_pos == 0)
        begin
            lead_score = 0;
            best_class = 0;
        end
        if (col_pos < 4)
            raw_xy[col_pos] = v;
        else if (corner)
        begin
            if (col_pos == 4)
                lead_score = v;
            else
                class_val = v;
        end
        else if (v > lead_score)
        begin
            lead_score = v;
            best_class = (col_pos - 4) & 8'hFF;
        end
        if (col_pos < cnt - 1)
        begin
            col_pos++;
            return;
        end
        keep = corner ? (class_val > -32768 && class_val < 32768) : (best_class == 0);
        if (lead_score < longint'(m_thresh))
            keep = 1'b0;
        if (keep)
        begin
            m = abs64(raw_xy[0]);
            for (int i = 1; i < 4; i++)
                if (abs64(raw_xy[i]) > m)
                    m = abs64(raw_xy[i]);
            sx = 1;
            sy = 1;
            if (m <= 131072)
            begin
                sx = m_fw;
                sy = m_fh;
            end
            px = longint'(m_pad_l) <<< 16;
            py = longint'(m_pad_t) <<< 16;
            ir = m_ratio;
            fw = longint'(m_fw) <<< 16;
            fh = longint'(m_fh) <<< 16;
            if (corner)
            begin
                l = round_shift((raw_xy[0] * sx - px) * ir, 16);
                t = round_shift((raw_xy[1] * sy - py) * ir, 16);
                r = round_shift((raw_xy[2] * sx - px) * ir, 16);
                b = round_shift((raw_xy[3] * sy - py) * ir, 16);
            end
            else
            begin
                cx = round_shift((raw_xy[0] * sx - px) * ir, 16);
                cy = round_shift((raw_xy[1] * sy - py) * ir, 16);
                hw = round_shift(raw_xy[2] * sx * ir, 17);
                hh = round_shift(raw_xy[3] * sy * ir, 17);
                l = cx - hw;
                r = cx + hw;
                t = cy - hh;
                b = cy + hh;
            end
            l = clip(l, fw);
            r = clip(r, fw);
            t = clip(t, fh);
            b = clip(b, fh);
            w = (r > l) ? r - l : 0;
            h = (b > t) ? b - t : 0;
            if (w > 0 && h > 0)
            begin
                box.box_left   = l[29:0];
                box.box_top    = t[29:0];
                box.box_w      = w[29:0];
                box.box_h      = h[29:0];
                box.score      = lead_score[30:0];
                box.row_number = row_pos[13:0];
                box.frame_done = it.last_row_of_frame;
                box_q = {box_q, box};
            end
        end
        col_pos = 0;
        if (it.last_row_of_frame || row_pos + 1 >= DEF_MAX_ROWS)
            row_pos = 0;
        else
            row_pos++;
    endtask

    // Called on a clock edge; returns on the edge that accepts the request.
    task automatic send_value(logic [31:0] v, bit lastf);
        in_item_t it;
        it.tensor_value = v;
        it.last_row_of_frame = lastf;
        if (max_gap > 0 && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, max_gap)) @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_box(it);
        items_sent++;
    endtask

    // Lower valid and wait until every box is out and the back stage is quiet.
    task automatic drain();
        in_valid <= 1'b0;
        while (box_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic load_config(int unsigned cc, fw, fh, pl, pt, ir, th);
        int unsigned vals [7];
        vals = '{cc, fw, fh, pl, pt, ir, th};
        drain();
        for (int i = 0; i < 7; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= vals[i][CFG_DATA_W-1:0];
            @(posedge clk);
            case (i[CFG_IDX_W-1:0])
                REG_COLUMN_COUNT:    m_count  = vals[i] & 32'hFF;
                REG_FRAME_WIDTH:     m_fw     = vals[i] & 32'h3FFF;
                REG_FRAME_HEIGHT:    m_fh     = vals[i] & 32'h3FFF;
                REG_PAD_LEFT:        m_pad_l  = vals[i] & 32'h1FFF;
                REG_PAD_TOP:         m_pad_t  = vals[i] & 32'h1FFF;
                REG_INVERSE_RATIO:   m_ratio  = vals[i] & 32'hFFFFFF;
                REG_SCORE_THRESHOLD: m_thresh = vals[i] & 32'h1FFFF;
                default: ;
            endcase
        end
        cfg_write <= 1'b0;
    endtask

    // One row with random content; noise rows are raw random words.
    task automatic send_row(bit noise, bit lastf);
        int unsigned cnt;
        bit          norm;
        logic [31:0] v;
        logic [31:0] c0, c1, s0;
        cnt = eff_count();
        norm = $urandom_range(0, 1);
        c0 = 0;
        c1 = 0;
        s0 = 0;
        for (int p = 0; p < cnt; p++)
        begin
            if (noise)
                v = $urandom;
            else if (p < 4)
            begin
                if (cnt == 6 && p >= 2)
                    v = ((p == 2) ? c0 : c1) + (norm ? $urandom_range(1, 40000)
                                                     : $urandom_range(1, 300 << 16));
                else
                    v = norm ? $urandom_range(0, 131072) : $urandom_range(0, 800 << 16);
                if ($urandom_range(0, 9) == 0)
                    v = -v;
                if (p == 0)
                    c0 = v;
                if (p == 1)
                    c1 = v;
            end
            else if (p == 4)
            begin
                v = $urandom_range(0, 80000);
                s0 = v;
            end
            else if (cnt == 6)
                v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 80000) - 40000
                                                : $urandom_range(0, 65535) - 32767;
            else
                case ($urandom_range(0, 9))
                    0:       v = s0;
                    1:       v = s0 + 1;
                    default: v = $urandom_range(0, s0);
                endcase
            send_value(v, (p == cnt - 1) ? lastf : $urandom_range(0, 1));
        end
    endtask

    task automatic test_reset_defaults();
        for (int i = 0; i < 3; i++)
            send_row(1'b0, i == 2);
    endtask

    task automatic test_corner_format();
        load_config(6, 640, 480, 16, 8, 65536, 16384);
        // class rounding edges: just inside and just outside zero
        send_value(32'd10 << 16, 0);  send_value(32'd20 << 16, 0);
        send_value(32'd90 << 16, 0);  send_value(32'd70 << 16, 0);
        send_value(32'd16384, 0);     send_value(32'd32767, 0);
        send_value(32'd0, 0);         send_value(32'd0, 0);
        send_value(32'd131072, 0);    send_value(32'd131072, 0);
        send_value(32'd65536, 0);     send_value(32'd32768, 1);
        send_value(32'd1, 0);         send_value(32'd2, 0);
        send_value(32'd60000, 0);     send_value(32'd50000, 0);
        send_value(32'd16383, 0);     send_value(-32'sd32767, 0);
    endtask

    task automatic test_center_argmax();
        load_config(8, 1920, 1080, 0, 140, 196608, 0);
        // tie on class 0 keeps class 0, a strictly larger class 1 drops the row
        send_value(32'd320 << 16, 0); send_value(32'd240 << 16, 0);
        send_value(32'd50 << 16, 0);  send_value(32'd40 << 16, 0);
        send_value(32'd30000, 0);     send_value(32'd30000, 0);
        send_value(32'd100, 0);       send_value(32'd0, 1);
        send_value(32'd65536, 0);     send_value(32'd65536, 0);
        send_value(32'd32768, 0);     send_value(32'd32768, 0);
        send_value(32'd30000, 0);     send_value(32'd30001, 0);
        send_value(32'd0, 0);         send_value(32'd0, 0);
    endtask

    task automatic test_extremes();
        load_config(6, 8192, 8192, 8191, 8191, 24'hFFFFFF, 65536);
        send_value(32'h80000000, 0);  send_value(32'h80000000, 0);
        send_value(32'h7FFFFFFF, 0);  send_value(32'h7FFFFFFF, 0);
        send_value(32'h7FFFFFFF, 0);  send_value(32'd0, 1);
        load_config(5, 1, 1, 0, 0, 1, 0);
        send_value(32'h80000000, 1);  send_value(32'h7FFFFFFF, 0);
        send_value(32'h7FFFFFFF, 0);  send_value(32'h7FFFFFFF, 0);
        send_value(32'hFFFFFFFF, 1);
        // zero frame size clips every box away
        load_config(6, 0, 0, 0, 0, 65536, 0);
        send_row(1'b0, 1'b1);
        send_row(1'b1, 1'b0);
    endtask

    task automatic test_count_limits();
        load_config(0, 640, 640, 0, 0, 65536, 100);
        send_row(1'b0, 0);
        load_config(255, 640, 640, 0, 0, 65536, 100);
        send_row(1'b0, 1);
        // shrink the row length in the middle of a row
        load_config(10, 640, 640, 0, 0, 65536, 100);
        repeat (7) send_value($urandom_range(0, 65536), 0);
        load_config(6, 640, 640, 0, 0, 65536, 100);
        do
            send_value($urandom_range(0, 65536), 0);
        while (col_pos != 0);
    endtask

    task automatic test_backpressure();
        load_config(5, 640, 640, 0, 0, 65536, 0);
        max_gap = 0;
        hold_left = 400;
        repeat (40) send_row(1'b0, 0);
        // pause until every box is out, then resume
        in_valid <= 1'b0;
        while (box_q.size() != 0)
            @(posedge clk);
        repeat (10) send_row(1'b0, 1);
    endtask

    task automatic test_random();
        int unsigned cc, fw, fh, pl, pt, ir, th;
        int          phase_end;
        while (items_sent < 1500)
        begin
            case ($urandom_range(0, 9))
                0:       cc = 128;
                1:       cc = $urandom_range(0, 1) ? 0 : 255;
                2, 3, 4: cc = 6;
                default: cc = $urandom_range(5, 12);
            endcase
            fw = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 1 : 8192)
                                            : $urandom_range(1, 8192);
            fh = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 1 : 8192)
                                            : $urandom_range(1, 8192);
            pl = $urandom_range(0, 5) == 0 ? $urandom_range(0, 8191) : $urandom_range(0, 64);
            pt = $urandom_range(0, 5) == 0 ? $urandom_range(0, 8191) : $urandom_range(0, 64);
            case ($urandom_range(0, 7))
                0:       ir = 1;
                1:       ir = 24'hFFFFFF;
                default: ir = $urandom_range(16384, 131072);
            endcase
            th = $urandom_range(0, 7) == 0 ? 65536 : $urandom_range(0, 40000);
            load_config(cc, fw, fh, pl, pt, ir, th);
            max_gap = $urandom_range(0, 2) * 4;
            stall_pct = $urandom_range(0, 3) * 20;
            phase_end = items_sent + $urandom_range(100, 220);
            while (items_sent < phase_end)
                send_row($urandom_range(0, 7) == 0, $urandom_range(0, 4) == 0);
        end
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (box_q.size() == 0)
            begin
                $display("%0t: unexpected box: expected none, actual %h", $time, out_data);
                errors++;
            end
            else
            begin
                want = box_q.pop_front();
                check_field("box_left", want.box_left, out_data.box_left);
                check_field("box_top", want.box_top, out_data.box_top);
                check_field("box_w", want.box_w, out_data.box_w);
                check_field("box_h", want.box_h, out_data.box_h);
                check_field("score", want.score, out_data.score);
                check_field("row_number", want.row_number, out_data.row_number);
                check_field("frame_done", want.frame_done, out_data.frame_done);
            end
        end
    end

    // receiver stall pattern, with an optional long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        max_gap = 3;
        burst_left = 0;
        stall_pct = 25;
        hold_left = 0;
        m_count = 84; m_fw = 640; m_fh = 640;
        m_pad_l = 0; m_pad_t = 0; m_ratio = 65536; m_thresh = 16384;
        col_pos = 0; row_pos = 0;
        raw_xy = '{0, 0, 0, 0};
        lead_score = 0; best_class = 0; class_val = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_corner_format();
        test_center_argmax();
        test_extremes();
        test_count_limits();
        test_backpressure();
        test_random();
        drain();
        if (errors == 0)
            $display("** detection_row_box_decoder: PASSED **");
        else
            $display("** detection_row_box_decoder: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
